/* hdl/matrix4_multiply_engine_top_defines.svh */
// Assertion macros for the 4x4 matrix multiply engine.
// Used by the modules in this folder; needs signals named clock and reset in scope.
`ifndef MATRIX4_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define MATRIX4_MULTIPLY_ENGINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MM4_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mm4 assertion failed");
`define MM4_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("mm4 assertion failed");
`else
`define MM4_ASSERT(lbl, prop)
`define MM4_NEVER(lbl, expr)
`endif

`endif

/* hdl/mm4_pkg.sv */
// Shared types and constants for the 4x4 matrix multiply engine.
// No dependencies.
`timescale 1ns / 1ps

package mm4_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int ENTRIES   = DIM * DIM;
   localparam int DIM_W     = $clog2(DIM);
   localparam int ENT_W     = $clog2(ENTRIES);
   localparam int IDX_W     = 4;
   localparam int VAL_W     = 32;
   localparam int PROD_W    = 2 * VAL_W;
   localparam int SUM_W     = PROD_W + $clog2(DIM);
   localparam int TDATA_W   = ((IDX_W + VAL_W + 7) / 8) * 8;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_WR_A = 2'd0,
      CMD_WR_B = 2'd1,
      CMD_MUL  = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic fin;
   } ctrl_type;

endpackage

/* hdl/matrix4_multiply_engine_top.sv */
// Top level of the 4x4 fixed-point matrix multiply engine (out = A*B, column-major).
// Depends on mm4_pkg, mm4_store and mm4_mac.
//
//  Channel  Dir  Handshake                 Payload
//  req      in   req_tvalid / req_tready   tuser: cmd; tdata: index, value
//  rsp      out  rsp_tvalid / rsp_tready   tdata: result_index, result_value; tlast
//
//  A multiply item emits 16 items, and each product entry needs 4 read pairs
//  from the single read port of each store.
//  The first item follows the four reads, the multiply, the sum and the response register.
//  Reset clears the per-entry valid bits; no clearing pass.
//  rsp_tready low while a response is held valid freezes the read, multiply and accumulate stages in place.
`timescale 1ns / 1ps
`include "matrix4_multiply_engine_top_defines.svh"

module matrix4_multiply_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_tuser,   // cmd
   input  logic [mm4_pkg::TDATA_W-1:0]   req_tdata,   // index[3:0], value[35:4], zero pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mm4_pkg::TDATA_W-1:0]   rsp_tdata,   // result_index[3:0], result_value[35:4]
   output logic                          rsp_tlast
);
   import mm4_pkg::*;

   state_type               state_ff;
   state_type               state_in;
   logic [DIM_W-1:0]        k_ff;
   logic [DIM_W-1:0]        row_ff;
   logic [DIM_W-1:0]        col_ff;
   logic [ENT_W-1:0]        out_cnt_ff;
   ctrl_type                ctrl1_ff;
   ctrl_type                ctrl1_in;
   logic                    rsp_valid_ff;
   logic [TDATA_W-1:0]      rsp_data_ff;
   logic                    rsp_last_ff;

   logic                    req_acc;
   logic                    adv;
   logic                    issue;
   logic                    issue_last;
   logic                    k_wrap;
   logic                    row_wrap;
   logic                    in_range;
   logic                    wr_a;
   logic                    wr_b;
   logic [IDX_W-1:0]        req_index;
   logic signed [VAL_W-1:0] req_value;
   logic [ENT_W-1:0]        rd_addr_a;
   logic [ENT_W-1:0]        rd_addr_b;
   logic signed [VAL_W-1:0] rd_a;
   logic signed [VAL_W-1:0] rd_b;
   logic                    res_vld;
   logic signed [VAL_W-1:0] res_value;
   logic                    out_last;

   assign req_index = req_tdata[IDX_W-1:0];
   assign req_value = req_tdata[IDX_W+VAL_W-1:IDX_W];
   assign req_acc   = req_tvalid && req_tready;
   assign in_range  = int'(req_index) < ENTRIES;
   assign wr_a      = req_acc && (req_tuser == CMD_WR_A) && in_range;
   assign wr_b      = req_acc && (req_tuser == CMD_WR_B) && in_range;

   assign adv       = !rsp_valid_ff || rsp_tready;
   assign k_wrap    = (k_ff == DIM_W'(DIM - 1));
   assign row_wrap  = (row_ff == DIM_W'(DIM - 1));
   assign issue_last = k_wrap && row_wrap && (col_ff == DIM_W'(DIM - 1));
   assign rd_addr_a = ENT_W'(int'(k_ff) * DIM + int'(row_ff));
   assign rd_addr_b = ENT_W'(int'(col_ff) * DIM + int'(k_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == CMD_MUL)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue && issue_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_RUN:  issue      = adv;
         default: begin
            req_tready = 1'b0;
            issue      = 1'b0;
         end
      endcase
   end

   always_comb begin
      ctrl1_in.vld   = issue;
      ctrl1_in.first = issue && (k_ff == '0);
      ctrl1_in.fin   = issue && k_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         ctrl1_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (adv) begin
            ctrl1_ff <= ctrl1_in;
         end
         if (issue) begin
            k_ff <= k_wrap ? '0 : k_ff + 1'b1;
            if (k_wrap) begin
               row_ff <= row_wrap ? '0 : row_ff + 1'b1;
               if (row_wrap) begin
                  col_ff <= (col_ff == DIM_W'(DIM - 1)) ? '0 : col_ff + 1'b1;
               end
            end
         end
      end
   end

   mm4_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_a      (wr_a),
      .wr_b      (wr_b),
      .wr_addr   (ENT_W'(req_index)),
      .wr_data   (req_value),
      .rd_en     (issue),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   mm4_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctrl      (ctrl1_ff),
      .a         (rd_a),
      .b         (rd_b),
      .res_vld   (res_vld),
      .res_value (res_value)
   );

   assign out_last = (out_cnt_ff == ENT_W'(ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         out_cnt_ff   <= '0;
      end else if (adv) begin
         rsp_valid_ff <= res_vld;
         if (res_vld) begin
            out_cnt_ff <= out_last ? '0 : out_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_vld) begin
         rsp_data_ff <= TDATA_W'({res_value, IDX_W'(out_cnt_ff)});
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `MM4_ASSERT(a_run_ends, issue && issue_last |=> state_ff == ST_IDLE)
   `MM4_ASSERT(a_stage1_hold, !adv |=> $stable(ctrl1_ff))
   `MM4_NEVER(a_last_count, rsp_tvalid && rsp_tlast && (out_cnt_ff != '0))

endmodule

/* hdl/mm4_store.sv */
// Matrix A and B stores: two synchronous memories with registered reads.
// Per-entry valid bits make unwritten entries read as zero. Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_store (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_a,
   input  logic                                wr_b,
   input  logic [mm4_pkg::ENT_W-1:0]           wr_addr,
   input  logic signed [mm4_pkg::VAL_W-1:0]    wr_data,
   input  logic                                rd_en,
   input  logic [mm4_pkg::ENT_W-1:0]           rd_addr_a,
   input  logic [mm4_pkg::ENT_W-1:0]           rd_addr_b,
   output logic signed [mm4_pkg::VAL_W-1:0]    rd_a,
   output logic signed [mm4_pkg::VAL_W-1:0]    rd_b
);
   import mm4_pkg::*;

   logic signed [VAL_W-1:0] mem_a [ENTRIES];
   logic signed [VAL_W-1:0] mem_b [ENTRIES];
   logic [ENTRIES-1:0]      vld_a_ff;
   logic [ENTRIES-1:0]      vld_b_ff;
   logic signed [VAL_W-1:0] rd_a_ff;
   logic signed [VAL_W-1:0] rd_b_ff;
   logic                    rd_vld_a_ff;
   logic                    rd_vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (wr_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_a[rd_addr_a];
         rd_b_ff <= mem_b[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff    <= '0;
         vld_b_ff    <= '0;
         rd_vld_a_ff <= 1'b0;
         rd_vld_b_ff <= 1'b0;
      end else begin
         if (wr_a) begin
            vld_a_ff[wr_addr] <= 1'b1;
         end
         if (wr_b) begin
            vld_b_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_a_ff <= vld_a_ff[rd_addr_a];
            rd_vld_b_ff <= vld_b_ff[rd_addr_b];
         end
      end
   end

   assign rd_a = rd_vld_a_ff ? rd_a_ff : '0;
   assign rd_b = rd_vld_b_ff ? rd_b_ff : '0;

endmodule

/* hdl/mm4_mac.sv */
// Multiply-accumulate unit: registered 32x32 product, wide accumulator,
// floor shift by FRAC_BITS and saturation to 32 bits. Depends on mm4_pkg.
`timescale 1ns / 1ps
`include "matrix4_multiply_engine_top_defines.svh"

module mm4_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  mm4_pkg::ctrl_type                   ctrl,
   input  logic signed [mm4_pkg::VAL_W-1:0]    a,
   input  logic signed [mm4_pkg::VAL_W-1:0]    b,
   output logic                                res_vld,
   output logic signed [mm4_pkg::VAL_W-1:0]    res_value
);
   import mm4_pkg::*;

   ctrl_type                 ctrl2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  base;
   logic signed [SUM_W-1:0]  acc_in;
   logic signed [SUM_W-1:0]  shifted;

   assign prod_in = PROD_W'(a) * PROD_W'(b);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
      end else if (adv) begin
         ctrl2_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         if (ctrl2_ff.vld) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_comb begin
      base    = ctrl2_ff.first ? '0 : acc_ff;
      acc_in  = base + SUM_W'(prod_ff);
      shifted = acc_in >>> FRAC_BITS;
      priority if (shifted > SUM_W'(VAL_MAX)) begin
         res_value = VAL_MAX;
      end else if (shifted < SUM_W'(VAL_MIN)) begin
         res_value = VAL_MIN;
      end else begin
         res_value = VAL_W'(shifted);
      end
   end

   assign res_vld = ctrl2_ff.vld && ctrl2_ff.fin;

   `MM4_ASSERT(a_mac_hold, !adv |=> $stable(acc_ff) && $stable(prod_ff) && $stable(ctrl2_ff))

endmodule
